### hw/rtl/adam_weight_update_macros.svh
// Assertion macros for the Adam weight update block
`ifndef ADAM_WEIGHT_UPDATE_MACROS_SVH
`define ADAM_WEIGHT_UPDATE_MACROS_SVH

// same-cycle implication
`define AWU_CHK_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AWU_CHK_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/awu_pkg.sv
// Shared constants and types of the Adam weight update block
`default_nettype none
package awu_pkg;
	localparam int DEPTH       = 4096;
	localparam int SLOT_W      = $clog2(DEPTH);
	localparam int IDX_W       = 12;
	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int BETA_W      = 16;
	localparam int LR_W        = 24;
	localparam int EPS_W       = 16;
	localparam int CORR_W      = 28;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 28;
	localparam int IN_TDATA_W  = ((IDX_W + 2 * DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;
	localparam int G2_W        = 2 * DATA_W - FRAC_W;
	localparam int PROD_W      = DATA_W + CORR_W;
	localparam int HALF_W      = PROD_W / 2;
	localparam int ROOT_W      = PROD_W / 2;
	localparam int NUM_W       = PROD_W + LR_W;
	localparam int DEN_W       = ROOT_W + 1;
	localparam int STEP_SH     = LR_W;
	localparam int STEP_LOG    = 33;
	localparam int STEP_W      = STEP_LOG + 1;
	localparam int QUO_W       = STEP_LOG + STEP_SH + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BETA_FIRST   = 3'd0,
		CFG_BETA_SECOND  = 3'd1,
		CFG_LEARN_RATE   = 3'd2,
		CFG_EPSILON      = 3'd3,
		CFG_FIRST_CORR   = 3'd4,
		CFG_SECOND_CORR  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] w;
		logic                     neg;
	} item_tag_t;

	typedef struct packed {
		item_tag_t        tag;
		logic [NUM_W-1:0] num;
	} sq_pay_t;
endpackage
`default_nettype wire

### hw/rtl/awu_moment.sv
// Moment stores with clearing pass, read-modify-write and forwarding
`default_nettype none
`include "adam_weight_update_macros.svh"
module awu_moment (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_vld,
	input  logic [awu_pkg::IDX_W-1:0]            in_idx,
	input  logic signed [awu_pkg::DATA_W-1:0]    in_grad,
	input  logic signed [awu_pkg::DATA_W-1:0]    in_weight,
	input  logic [awu_pkg::BETA_W-1:0]           beta_first,
	input  logic [awu_pkg::BETA_W-1:0]           beta_second,
	output logic                                 clr_busy,
	output logic                                 vld_s3,
	output awu_pkg::item_tag_t                   tag_s3,
	output logic signed [awu_pkg::DATA_W-1:0]    m_s3,
	output logic [awu_pkg::DATA_W-1:0]           v_s3
);
	localparam int DW    = awu_pkg::DATA_W;
	localparam int FW    = awu_pkg::FRAC_W;
	localparam int SW    = awu_pkg::SLOT_W;
	localparam int G2W   = awu_pkg::G2_W;
	localparam int GSQ_W = 2 * DW;
	localparam int HALF  = 1 << (FW - 1);
	localparam int MD_W  = DW + 1;
	localparam int MA_W  = awu_pkg::BETA_W + 1 + MD_W;
	localparam int MS_W  = MA_W + 1;
	localparam int MR_W  = MS_W - FW;
	localparam int VD_W  = G2W + 1;
	localparam int VA_W  = awu_pkg::BETA_W + 1 + VD_W;
	localparam int VS_W  = VA_W + 1;
	localparam int VR_W  = VS_W - FW;

	logic [2*DW-1:0] mem_q [awu_pkg::DEPTH];
	logic            clr_busy_q;
	logic [SW-1:0]   clr_addr_q;

	logic                          vld_s1, vld_s2;
	logic [awu_pkg::IDX_W-1:0]     idx_s1, idx_s2;
	logic signed [DW-1:0]          g_s1, g_s2, w_s1, w_s2;
	logic [G2W-1:0]                g2_s2;
	logic [2*DW-1:0]               rd_s2;

	logic                 last_vld_q;
	logic [SW-1:0]        last_slot_q;
	logic signed [DW-1:0] last_m_q;
	logic [DW-1:0]        last_v_q;

	logic [DW-1:0]          gmag;
	logic [GSQ_W-1:0]       gsq;
	logic [G2W-1:0]         g2_c;
	logic [SW-1:0]          slot_s1, slot_s2;
	logic                   fwd;
	logic signed [DW-1:0]   m_old, m_new;
	logic [DW-1:0]          v_old, v_new;
	logic signed [MD_W-1:0] m_diff;
	logic signed [MA_W-1:0] m_acc;
	logic signed [MS_W-1:0] m_sum;
	logic [MR_W-1:0]        m_rnd;
	logic signed [VD_W-1:0] v_diff;
	logic signed [VA_W-1:0] v_acc;
	logic [VS_W-1:0]        v_sum;
	logic [VR_W-1:0]        v_rnd;

	assign clr_busy = clr_busy_q;
	assign slot_s1  = idx_s1[SW-1:0];
	assign slot_s2  = idx_s2[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == SW'(awu_pkg::DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// stage 1: gradient square
	always_comb begin
		gmag = g_s1[DW-1] ? DW'(-g_s1) : DW'(g_s1);
		gsq  = GSQ_W'(gmag) * GSQ_W'(gmag);
		g2_c = G2W'((gsq + GSQ_W'(HALF)) >> FW);
	end

	// stage 2: moment update, forwarded from the latest write
	always_comb begin
		fwd    = last_vld_q && (last_slot_q == slot_s2);
		m_old  = fwd ? last_m_q : $signed(rd_s2[DW-1:0]);
		v_old  = fwd ? last_v_q : rd_s2[2*DW-1:DW];
		m_diff = MD_W'(m_old) - MD_W'(g_s2);
		m_acc  = $signed({1'b0, beta_first}) * m_diff;
		m_sum  = MS_W'(m_acc) + (MS_W'(g_s2) <<< FW) + MS_W'(HALF);
		m_rnd  = m_sum[MS_W-1:FW];
		if (m_rnd[MR_W-1:DW-1] == '0 || m_rnd[MR_W-1:DW-1] == '1) begin
			m_new = $signed(m_rnd[DW-1:0]);
		end else begin
			m_new = m_rnd[MR_W-1] ? $signed({1'b1, {(DW-1){1'b0}}})
			                      : $signed({1'b0, {(DW-1){1'b1}}});
		end
		v_diff = $signed(VD_W'(v_old)) - $signed({1'b0, g2_s2});
		v_acc  = $signed({1'b0, beta_second}) * v_diff;
		v_sum  = VS_W'(v_acc) + VS_W'({g2_s2, FW'(0)}) + VS_W'(HALF);
		v_rnd  = v_sum[VS_W-1:FW];
		v_new  = (|v_rnd[VR_W-1:DW]) ? '1 : v_rnd[DW-1:0];
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (en && vld_s2) begin
			mem_q[slot_s2] <= {v_new, m_new};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s2 <= mem_q[slot_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			last_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s2) begin
				last_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= in_idx;
			g_s1   <= in_grad;
			w_s1   <= in_weight;
			idx_s2 <= idx_s1;
			g_s2   <= g_s1;
			w_s2   <= w_s1;
			g2_s2  <= g2_c;
			tag_s3 <= '{idx: idx_s2, w: w_s2, neg: m_new[DW-1]};
			m_s3   <= m_new;
			v_s3   <= v_new;
			if (vld_s2) begin
				last_slot_q <= slot_s2;
				last_m_q    <= m_new;
				last_v_q    <= v_new;
			end
		end
	end

	`AWU_CHK_NOW(a_clr_no_items, clk, arst_n, clr_busy_q, !vld_s1 && !vld_s2, "item during clear")
	`AWU_CHK_NXT(a_stall_hold, clk, arst_n, !en && vld_s3, vld_s3 && $stable(m_s3) && $stable(v_s3), "moment changed in stall")
endmodule
`default_nettype wire

### hw/rtl/awu_sqrt.sv
// Pipelined integer square root, two result bits per stage
`default_nettype none
module awu_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [awu_pkg::PROD_W-1:0]   in_x,
	input  awu_pkg::sq_pay_t             in_pay,
	output logic                         out_vld,
	output logic [awu_pkg::ROOT_W-1:0]   out_root,
	output awu_pkg::sq_pay_t             out_pay
);
	localparam int XW    = awu_pkg::PROD_W;
	localparam int RW    = awu_pkg::ROOT_W;
	localparam int REM_W = RW + 2;
	localparam int TW    = REM_W + 2;
	localparam int NSQ   = RW / 2;

	function automatic logic [REM_W+RW-1:0] sq_step(input logic [REM_W-1:0] rem,
		input logic [RW-1:0] root, input logic [1:0] xb);
		logic [TW-1:0] t;
		logic [TW-1:0] trial;
		t     = {rem, xb};
		trial = TW'({root, 2'b01});
		if (t >= trial) begin
			sq_step = {REM_W'(t - trial), root[RW-2:0], 1'b1};
		end else begin
			sq_step = {t[REM_W-1:0], root[RW-2:0], 1'b0};
		end
	endfunction

	logic                  vld_s  [NSQ];
	logic [RW-1:0]         root_s [NSQ];
	awu_pkg::sq_pay_t      pay_s  [NSQ];
	logic [REM_W-1:0]      rem_s  [NSQ-1];
	logic [XW-1:0]         x_s    [NSQ-1];

	for (genvar k = 0; k < NSQ; k++) begin : g_st
		logic                  vld_in;
		logic [REM_W-1:0]      rem_in;
		logic [RW-1:0]         root_in;
		logic [XW-1:0]         x_in;
		awu_pkg::sq_pay_t      pay_in;
		logic [REM_W+RW-1:0]   sa, sb;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = in_x;
			assign pay_in  = in_pay;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in    = x_s[k-1];
			assign pay_in  = pay_s[k-1];
		end

		assign sa = sq_step(rem_in, root_in, x_in[XW-1-4*k -: 2]);
		assign sb = sq_step(sa[REM_W+RW-1:RW], sa[RW-1:0], x_in[XW-3-4*k -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= sb[RW-1:0];
				pay_s[k]  <= pay_in;
			end
		end

		if (k < NSQ - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= sb[REM_W+RW-1:RW];
					x_s[k]   <= x_in;
				end
			end
		end
	end

	assign out_vld  = vld_s[NSQ-1];
	assign out_root = root_s[NSQ-1];
	assign out_pay  = pay_s[NSQ-1];
endmodule
`default_nettype wire

### hw/rtl/awu_div.sv
// Pipelined restoring divider with quotient overflow flag, two bits per stage
`default_nettype none
module awu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [awu_pkg::NUM_W-1:0]   in_num,
	input  logic [awu_pkg::DEN_W-1:0]   in_den,
	input  awu_pkg::item_tag_t          in_tag,
	output logic                        out_vld,
	output logic [awu_pkg::QUO_W-1:0]   out_quo,
	output logic                        out_ovf,
	output awu_pkg::item_tag_t          out_tag
);
	localparam int NW  = awu_pkg::NUM_W;
	localparam int DW  = awu_pkg::DEN_W;
	localparam int QW  = awu_pkg::QUO_W;
	localparam int NDV = QW / 2;

	function automatic logic [DW:0] dv_step(input logic [DW-1:0] rem, input logic nb,
		input logic [DW-1:0] den);
		logic [DW:0] t;
		t = {rem, nb};
		if (t >= {1'b0, den}) begin
			dv_step = {1'b1, DW'(t - {1'b0, den})};
		end else begin
			dv_step = {1'b0, t[DW-1:0]};
		end
	endfunction

	logic                 vld_s0, ovf_s0;
	logic [DW-1:0]        rem_s0, den_s0;
	logic [QW-1:0]        lo_s0;
	awu_pkg::item_tag_t   tag_s0;

	logic                 vld_s [NDV];
	logic                 ovf_s [NDV];
	logic [QW-1:0]        quo_s [NDV];
	awu_pkg::item_tag_t   tag_s [NDV];
	logic [DW-1:0]        rem_s [NDV-1];
	logic [DW-1:0]        den_s [NDV-1];
	logic [QW-1:0]        lo_s  [NDV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s0 <= DW'(in_num[NW-1:QW]) >= in_den;
			rem_s0 <= DW'(in_num[NW-1:QW]);
			den_s0 <= in_den;
			lo_s0  <= in_num[QW-1:0];
			tag_s0 <= in_tag;
		end
	end

	for (genvar k = 0; k < NDV; k++) begin : g_st
		logic                vld_in, ovf_in;
		logic [DW-1:0]       rem_in, den_in;
		logic [QW-1:0]       lo_in, quo_in;
		awu_pkg::item_tag_t  tag_in;
		logic [DW:0]         da, db;

		if (k == 0) begin : g_first
			assign vld_in = vld_s0;
			assign ovf_in = ovf_s0;
			assign rem_in = rem_s0;
			assign den_in = den_s0;
			assign lo_in  = lo_s0;
			assign quo_in = '0;
			assign tag_in = tag_s0;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign ovf_in = ovf_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign quo_in = quo_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		assign da = dv_step(rem_in, lo_in[QW-1-2*k], den_in);
		assign db = dv_step(da[DW-1:0], lo_in[QW-2-2*k], den_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[k] <= ovf_in;
				quo_s[k] <= {quo_in[QW-3:0], da[DW], db[DW]};
				tag_s[k] <= tag_in;
			end
		end

		if (k < NDV - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= db[DW-1:0];
					den_s[k] <= den_in;
					lo_s[k]  <= lo_in;
				end
			end
		end
	end

	assign out_vld = vld_s[NDV-1];
	assign out_quo = quo_s[NDV-1];
	assign out_ovf = ovf_s[NDV-1];
	assign out_tag = tag_s[NDV-1];
endmodule
`default_nettype wire

### hw/rtl/adam_weight_update.sv
// Top level of the Adam weight update block
//
// channel  dir  handshake                      payload
// s_*      in   s_tvalid / s_tready            elem_index, gradient, weight_in
// m_*      out  m_tvalid / m_tready            index_out, weight_out
// cfg_*    in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One item per cycle while the output is not stalled and no clearing pass runs.
// Latency is set by the 15-stage square root and the 30-stage step divider.
// After reset a clearing pass zeroes all 4096 moment entries; s_tready stays low meanwhile.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
`include "adam_weight_update_macros.svh"
module adam_weight_update (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [awu_pkg::IN_TDATA_W-1:0]      s_tdata,   // elem_index, gradient, weight_in, pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [awu_pkg::OUT_TDATA_W-1:0]     m_tdata,   // index_out, weight_out, pad
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [awu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [awu_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int IW     = awu_pkg::IDX_W;
	localparam int DW     = awu_pkg::DATA_W;
	localparam int PW     = awu_pkg::PROD_W;
	localparam int HW     = awu_pkg::HALF_W;
	localparam int LW     = awu_pkg::LR_W;
	localparam int NW     = awu_pkg::NUM_W;
	localparam int PPW    = LW + HW;
	localparam int QW     = awu_pkg::QUO_W;
	localparam int DNW    = awu_pkg::DEN_W;
	localparam int SH     = awu_pkg::STEP_SH;
	localparam int STW    = awu_pkg::STEP_W;
	localparam int RSH_W  = QW + 1 - SH;
	localparam int RES_W  = STW + 2;
	localparam int PAD_W  = awu_pkg::OUT_TDATA_W - IW - DW;
	localparam logic [RSH_W-1:0] RSH_CLAMP  = RSH_W'(1) << awu_pkg::STEP_LOG;
	localparam logic [STW-1:0]   STEP_CLAMP = STW'(1) << awu_pkg::STEP_LOG;

	logic [awu_pkg::BETA_W-1:0] b1_q, b2_q;
	logic [LW-1:0]              lr_q;
	logic [awu_pkg::EPS_W-1:0]  eps_q;
	logic [awu_pkg::CORR_W-1:0] corr1_q, corr2_q;

	logic en, in_vld, clr_busy;

	logic                 vld_s3;
	awu_pkg::item_tag_t   tag_s3;
	logic signed [DW-1:0] m_s3;
	logic [DW-1:0]        v_s3;

	logic [DW-1:0]        mmag;
	logic                 vld_s4, vld_s5, vld_s6;
	awu_pkg::item_tag_t   tag_s4, tag_s5;
	logic [PW-1:0]        x_s4, x_s5, x_s6, p_s4;
	logic [PPW-1:0]       plo_s5, phi_s5;
	awu_pkg::sq_pay_t     pay_s6;

	logic                 vld_s21;
	logic [awu_pkg::ROOT_W-1:0] root_s21;
	awu_pkg::sq_pay_t     pay_s21;
	logic [DNW-1:0]       den_c;

	logic                 vld_s22;
	logic [DNW-1:0]       den_s22;
	logic [NW-1:0]        num_s22;
	awu_pkg::item_tag_t   tag_s22;

	logic                 vld_s52, ovf_s52;
	logic [QW-1:0]        quo_s52;
	awu_pkg::item_tag_t   tag_s52;

	logic [QW:0]          dsum;
	logic [RSH_W-1:0]     rsh;
	logic [STW-1:0]       step_c;
	logic                 vld_s53;
	logic [STW-1:0]       step_s53;
	awu_pkg::item_tag_t   tag_s53;
	logic signed [RES_W-1:0] res;
	logic signed [DW-1:0]    res_sat;

	assign cfg_ready = 1'b1;
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en && !clr_busy;
	assign in_vld    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q    <= awu_pkg::BETA_W'(58982);
			b2_q    <= awu_pkg::BETA_W'(65470);
			lr_q    <= LW'(16777);
			eps_q   <= awu_pkg::EPS_W'(1);
			corr1_q <= awu_pkg::CORR_W'(655360);
			corr2_q <= awu_pkg::CORR_W'(65536000);
		end else if (cfg_valid && cfg_ready) begin
			case (awu_pkg::cfg_reg_t'(cfg_index))
				awu_pkg::CFG_BETA_FIRST:  b1_q    <= cfg_data[awu_pkg::BETA_W-1:0];
				awu_pkg::CFG_BETA_SECOND: b2_q    <= cfg_data[awu_pkg::BETA_W-1:0];
				awu_pkg::CFG_LEARN_RATE:  lr_q    <= cfg_data[LW-1:0];
				awu_pkg::CFG_EPSILON:     eps_q   <= cfg_data[awu_pkg::EPS_W-1:0];
				awu_pkg::CFG_FIRST_CORR:  corr1_q <= cfg_data[awu_pkg::CORR_W-1:0];
				awu_pkg::CFG_SECOND_CORR: corr2_q <= cfg_data[awu_pkg::CORR_W-1:0];
				default: ;
			endcase
		end
	end

	awu_moment u_moment (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (in_vld),
		.in_idx      (s_tdata[IW-1:0]),
		.in_grad     ($signed(s_tdata[IW+DW-1:IW])),
		.in_weight   ($signed(s_tdata[IW+2*DW-1:IW+DW])),
		.beta_first  (b1_q),
		.beta_second (b2_q),
		.clr_busy    (clr_busy),
		.vld_s3      (vld_s3),
		.tag_s3      (tag_s3),
		.m_s3        (m_s3),
		.v_s3        (v_s3)
	);

	assign mmag = tag_s3.neg ? DW'(-m_s3) : DW'(m_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			vld_s22  <= 1'b0;
			vld_s53  <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_s22  <= vld_s21;
			vld_s53  <= vld_s52;
			m_tvalid <= vld_s53;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4   <= PW'(v_s3) * PW'(corr2_q);
			p_s4   <= PW'(mmag) * PW'(corr1_q);
			tag_s4 <= tag_s3;
			x_s5   <= x_s4;
			plo_s5 <= PPW'(lr_q) * PPW'(p_s4[HW-1:0]);
			phi_s5 <= PPW'(lr_q) * PPW'(p_s4[PW-1:HW]);
			tag_s5 <= tag_s4;
			x_s6   <= x_s5;
			pay_s6 <= '{tag: tag_s5, num: (NW'(phi_s5) << HW) + NW'(plo_s5)};
		end
	end

	awu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.in_x     (x_s6),
		.in_pay   (pay_s6),
		.out_vld  (vld_s21),
		.out_root (root_s21),
		.out_pay  (pay_s21)
	);

	always_comb begin
		den_c = DNW'(root_s21) + DNW'(eps_q);
		if (den_c == '0) begin
			den_c = DNW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s22 <= den_c;
			num_s22 <= pay_s21.num;
			tag_s22 <= pay_s21.tag;
		end
	end

	awu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s22),
		.in_num  (num_s22),
		.in_den  (den_s22),
		.in_tag  (tag_s22),
		.out_vld (vld_s52),
		.out_quo (quo_s52),
		.out_ovf (ovf_s52),
		.out_tag (tag_s52)
	);

	// round to nearest, clamp to 2^33
	always_comb begin
		dsum = (QW + 1)'(quo_s52) + (QW + 1)'(1 << (SH - 1));
		rsh  = dsum[QW:SH];
		if (ovf_s52 || rsh > RSH_CLAMP) begin
			step_c = STEP_CLAMP;
		end else begin
			step_c = rsh[STW-1:0];
		end
	end

	always_comb begin
		if (tag_s53.neg) begin
			res = RES_W'(tag_s53.w) - $signed(RES_W'(step_s53));
		end else begin
			res = RES_W'(tag_s53.w) + $signed(RES_W'(step_s53));
		end
		if (res[RES_W-1:DW-1] == '0 || res[RES_W-1:DW-1] == '1) begin
			res_sat = res[DW-1:0];
		end else begin
			res_sat = res[RES_W-1] ? $signed({1'b1, {(DW-1){1'b0}}})
			                       : $signed({1'b0, {(DW-1){1'b1}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s53 <= step_c;
			tag_s53  <= tag_s52;
			m_tdata  <= {PAD_W'(0), res_sat, tag_s53.idx};
		end
	end

	`AWU_CHK_NOW(a_clr_no_output, clk, arst_n, clr_busy, !m_tvalid && !vld_s53, "result during clear")
	`AWU_CHK_NXT(a_step_clamped, clk, arst_n, en && vld_s52, step_s53 <= STEP_CLAMP, "step above clamp")
endmodule
`default_nettype wire

### dv/tb_adam_weight_update.sv
// Testbench for the Adam weight update block: directed corners and random streams against a predictor
`default_nettype none
module tb_adam_weight_update;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [awu_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd6;
	localparam logic [awu_pkg::CFG_IDX_W-1:0] CFG_LAST_IDX = 3'd7;
	localparam int DRAIN_CYCLES = 70;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;
	localparam longint unsigned STEP_MAX = 64'd1 << 33;

	typedef struct {
		logic [awu_pkg::IDX_W-1:0] idx;
		logic [awu_pkg::DATA_W-1:0] weight;
	} update_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [awu_pkg::IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [awu_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [awu_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [awu_pkg::CFG_DATA_W-1:0] cfg_data;

	adam_weight_update dut (.*);

	longint unsigned beta1, beta2, alpha, eps, corr1, corr2;
	longint moment_first [awu_pkg::DEPTH];
	longint unsigned moment_second [awu_pkg::DEPTH];
	update_t pending_updates[$];
	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clip32(longint x);
		if (x > SAT_MAX) return SAT_MAX;
		if (x < SAT_MIN) return SAT_MIN;
		return x;
	endfunction

	function automatic update_t adam_step(logic [awu_pkg::IDX_W-1:0] idx,
			logic signed [awu_pkg::DATA_W-1:0] grad,
			logic signed [awu_pkg::DATA_W-1:0] w);
		update_t u;
		longint g, m, res;
		longint unsigned gmag, g2, v, s, den, mmag, p, q, r, d, step;
		int slot;
		slot = idx % awu_pkg::DEPTH;
		g = grad;
		m = (longint'(beta1) * moment_first[slot] + longint'(65536 - beta1) * g + 32768) >>> 16;
		m = clip32(m);
		moment_first[slot] = m;
		gmag = (g < 0) ? -g : g;
		g2 = (gmag * gmag + 32768) >> 16;
		v = (beta2 * moment_second[slot] + (65536 - beta2) * g2 + 32768) >> 16;
		if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
		moment_second[slot] = v;
		s = int_sqrt(v * corr2);
		den = s + eps;
		if (den == 0) den = 1;
		mmag = (m < 0) ? -m : m;
		p = mmag * corr1;
		q = p / den;
		r = p % den;
		if (alpha == 0) begin
			step = 0;
		end else if (q > (64'd1 << 57) / alpha) begin
			step = STEP_MAX;
		end else begin
			d = alpha * q + (alpha * r) / den;
			step = (d + (64'd1 << 23)) >> 24;
			if (step > STEP_MAX) step = STEP_MAX;
		end
		res = (m < 0) ? longint'(w) - longint'(step) : longint'(w) + longint'(step);
		u.idx = idx;
		u.weight = awu_pkg::DATA_W'(clip32(res));
		return u;
	endfunction

	task automatic write_reg(logic [awu_pkg::CFG_IDX_W-1:0] idx,
			logic [awu_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			awu_pkg::CFG_BETA_FIRST: beta1 = val[awu_pkg::BETA_W-1:0];
			awu_pkg::CFG_BETA_SECOND: beta2 = val[awu_pkg::BETA_W-1:0];
			awu_pkg::CFG_LEARN_RATE: alpha = val[awu_pkg::LR_W-1:0];
			awu_pkg::CFG_EPSILON: eps = val[awu_pkg::EPS_W-1:0];
			awu_pkg::CFG_FIRST_CORR: corr1 = val[awu_pkg::CORR_W-1:0];
			awu_pkg::CFG_SECOND_CORR: corr2 = val[awu_pkg::CORR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int b1, int b2, int lr, int ep, int c1, int c2);
		write_reg(awu_pkg::CFG_BETA_FIRST, awu_pkg::CFG_DATA_W'(b1));
		write_reg(awu_pkg::CFG_BETA_SECOND, awu_pkg::CFG_DATA_W'(b2));
		write_reg(awu_pkg::CFG_LEARN_RATE, awu_pkg::CFG_DATA_W'(lr));
		write_reg(awu_pkg::CFG_EPSILON, awu_pkg::CFG_DATA_W'(ep));
		write_reg(awu_pkg::CFG_FIRST_CORR, awu_pkg::CFG_DATA_W'(c1));
		write_reg(awu_pkg::CFG_SECOND_CORR, awu_pkg::CFG_DATA_W'(c2));
	endtask

	task automatic send_item(logic [awu_pkg::IDX_W-1:0] idx, logic [awu_pkg::DATA_W-1:0] grad,
			logic [awu_pkg::DATA_W-1:0] w, bit bursty);
		if (bursty && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(awu_pkg::IN_TDATA_W - awu_pkg::IDX_W - 2 * awu_pkg::DATA_W){1'b0}},
			w, grad, idx};
		do @(posedge clk); while (!s_tready);
		pending_updates.push_back(adam_step(idx, grad, w));
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [awu_pkg::DATA_W-1:0] rand_grad();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return {{16{1'b0}}, 16'($urandom)};
			2: return -$signed({16'd0, 16'($urandom)});
			default: return $signed(20'($urandom)) <<< 8;
		endcase
	endfunction

	task automatic test_directed_defaults();
		send_item(0, 0, 0, 0);
		send_item(4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_item(4095, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_item(2, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		repeat (4) send_item(5, 32'h0001_0000, 32'hFFFF_0000, 0);
		send_item(5, 32'hFFFF_FFFF, 32'h0000_0001, 0);
		send_item(12'hAAA, 32'hAAAA_AAAA, 32'h5555_5555, 0);
		send_item(12'h555, 32'h5555_5555, 32'hAAAA_AAAA, 0);
		drain();
	endtask

	task automatic test_corner_settings();
		// no epsilon and no second correction: zero denominator, then clamped steps
		apply_settings(0, 0, 24'hFF_FFFF, 0, 28'hFFF_FFFF, 0);
		send_item(7, 0, 32'h0000_1234, 0);
		send_item(8, 32'h7FFF_FFFF, 0, 0);
		send_item(9, 32'h8000_0000, 0, 0);
		send_item(10, 1, 32'h7FFF_0000, 0);
		send_item(11, 32'hFFFF_FFFF, 32'h8000_FFFF, 0);
		drain();
		write_reg(CFG_SPARE_IDX, 28'hFFF_FFFF);
		write_reg(CFG_LAST_IDX, 0);
		apply_settings(16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 28'hFFF_FFFF);
		send_item(12, 32'h7FFF_FFFF, 32'h1234_5678, 0);
		send_item(12, 32'h8000_0000, 32'h8765_4321, 0);
		drain();
	endtask

	task automatic random_phase(int count);
		logic [awu_pkg::IDX_W-1:0] idx;
		repeat (count) begin
			idx = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 7)) : 12'($urandom);
			send_item(idx, rand_grad(), $urandom, 1);
		end
		drain();
	endtask

	task automatic test_random_settings();
		apply_settings(58982, 65470, 16777, 1, 655360, 65536000);
		random_phase(200);
		apply_settings(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 16'hFFFF, 28'hFFF_FFFF, 28'hFFF_FFFF);
		random_phase(150);
		apply_settings(0, 0, 0, 0, 0, 0);
		random_phase(100);
		repeat (3) begin
			apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 65535),
				$urandom_range(0, 28'hFFF_FFFF), $urandom_range(0, 28'hFFF_FFFF));
			random_phase(135);
		end
	endtask

	always @(posedge clk) begin
		update_t exp_u;
		logic [awu_pkg::IDX_W-1:0] got_idx;
		logic [awu_pkg::DATA_W-1:0] got_w;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_idx = m_tdata[awu_pkg::IDX_W-1:0];
				got_w = m_tdata[awu_pkg::IDX_W+awu_pkg::DATA_W-1:awu_pkg::IDX_W];
				if (pending_updates.size() == 0) begin
					$display("%0t unexpected transaction: index %0d weight %h", $time, got_idx,
						got_w);
					errors++;
				end else begin
					exp_u = pending_updates.pop_front();
					results_checked++;
					if (got_idx !== exp_u.idx) begin
						$display("%0t index_out: expected %0d actual %0d", $time, exp_u.idx,
							got_idx);
						errors++;
					end
					if (got_w !== exp_u.weight) begin
						$display("%0t weight_out (index %0d): expected %h actual %h", $time,
							exp_u.idx, exp_u.weight, got_w);
						errors++;
					end
				end
			end
			if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= (cycles % 5 < 2);
				default: m_tready <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout, %0d transactions still expected", $time,
				pending_updates.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		beta1 = 58982;
		beta2 = 65470;
		alpha = 16777;
		eps = 1;
		corr1 = 655360;
		corr2 = 65536000;
		foreach (moment_first[i]) begin
			moment_first[i] = 0;
			moment_second[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_corner_settings();
		test_random_settings();
		$display("%0d items sent, %0d updates checked over default, extreme and random settings",
			items_sent, results_checked);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/awu_pkg.sv
hw/rtl/awu_moment.sv
hw/rtl/awu_sqrt.sv
hw/rtl/awu_div.sv
hw/rtl/adam_weight_update.sv
dv/tb_adam_weight_update.sv
